### rtl/gdac_pkg.sv
// ----------------------------------------------------------------------------
// Greedy anchor cover package
// Shared word types, op codes, state encoding and size defaults.
// ----------------------------------------------------------------------------
package gdac_pkg;

    localparam int C_MAX_NODES   = 1024;
    localparam int C_MAX_EDGES   = 8192;
    localparam int C_ANCHOR_CAP  = 64;
    localparam int C_LIMIT_W     = 7;
    localparam logic [C_LIMIT_W-1:0] C_LIMIT_RESET = 7'd64;

    localparam logic [1:0] OP_ROW = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_RUN = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] neighbor;
    } t_in_word;

    typedef struct packed {
        logic [5:0]  step;
        logic [9:0]  anchor;
        logic [13:0] degree;
        logic [10:0] fresh_count;
        logic [10:0] cover_sum;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic busy;
        logic push;
    } t_sel_status;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SCAN, S_TAIL, S_DECIDE, S_MARK,
        S_NBRD, S_CVRD, S_CVEV, S_FIN, S_FLUSH
    } t_sel_state;

endpackage

### rtl/gdac_graph.sv
// ----------------------------------------------------------------------------
// Graph store
// Row table and neighbor memory, filled by row and neighbor words.
// ----------------------------------------------------------------------------
module gdac_graph #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 8192,
    localparam int VIW = $clog2(MAX_NODES),
    localparam int NW  = $clog2(MAX_NODES + 1),
    localparam int EIW = $clog2(MAX_EDGES),
    localparam int EW  = $clog2(MAX_EDGES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  gdac_pkg::t_in_word  i_word,
    input  logic [VIW-1:0]      i_row_ra,
    input  logic [EIW-1:0]      i_nb_ra,
    output logic [EW-1:0]       o_row_start,
    output logic [EW-1:0]       o_row_len,
    output logic [9:0]          o_nb,
    output logic [NW-1:0]       o_vcount
);
    import gdac_pkg::*;

    logic [2*EW-1:0] rowmem [MAX_NODES];
    logic [9:0]      nbmem  [MAX_EDGES];

    logic [NW-1:0]   r_vc;
    logic [EW-1:0]   r_ec;
    logic            r_open;
    logic [EW-1:0]   r_cur_start;
    logic [EW-1:0]   r_cur_len;
    logic [2*EW-1:0] r_rowq;
    logic [9:0]      r_nbq;

    logic            row_we;
    logic [VIW-1:0]  row_wa;
    logic [2*EW-1:0] row_wd;
    logic            nb_we;

    always_comb begin
        row_we = 1'b0;
        row_wa = VIW'(r_vc);
        row_wd = {r_ec, EW'(0)};
        nb_we  = 1'b0;
        if (i_load && i_word.op == OP_ROW && 32'(r_vc) < MAX_NODES) begin
            row_we = 1'b1;
        end else if (i_load && i_word.op == OP_ADD && r_open && r_vc != '0
                     && 32'(r_ec) < MAX_EDGES) begin
            row_we = 1'b1;
            nb_we  = 1'b1;
            row_wa = VIW'(r_vc - 1'b1);
            row_wd = {r_cur_start, EW'(r_cur_len + 1'b1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc   <= '0;
            r_ec   <= '0;
            r_open <= 1'b0;
        end else if (i_load && i_word.op == OP_ROW) begin
            if (row_we) begin
                r_vc        <= r_vc + 1'b1;
                r_open      <= 1'b1;
                r_cur_start <= r_ec;
                r_cur_len   <= '0;
            end else begin
                r_open <= 1'b0;
            end
        end else if (nb_we) begin
            r_ec      <= r_ec + 1'b1;
            r_cur_len <= r_cur_len + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            rowmem[row_wa] <= row_wd;
        end
        if (nb_we) begin
            nbmem[EIW'(r_ec)] <= i_word.neighbor;
        end
        r_rowq <= rowmem[i_row_ra];
        r_nbq  <= nbmem[i_nb_ra];
    end

    assign o_row_start = r_rowq[2*EW-1:EW];
    assign o_row_len   = r_rowq[EW-1:0];
    assign o_nb        = r_nbq;
    assign o_vcount    = r_vc;

endmodule

### rtl/gdac_select.sv
// ----------------------------------------------------------------------------
// Anchor selector
// Covered-mark memory and the sequencer that scans, covers and reports.
// ----------------------------------------------------------------------------
module gdac_select #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 8192,
    parameter int ANCHOR_CAP  = 64,
    localparam int VIW = $clog2(MAX_NODES),
    localparam int NW  = $clog2(MAX_NODES + 1),
    localparam int EIW = $clog2(MAX_EDGES),
    localparam int EW  = $clog2(MAX_EDGES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_run,
    input  logic [gdac_pkg::C_LIMIT_W-1:0] i_limit,
    input  logic [NW-1:0]                 i_vcount,
    input  logic [EW-1:0]                 i_row_start,
    input  logic [EW-1:0]                 i_row_len,
    input  logic [9:0]                    i_nb,
    input  logic                          i_out_free,
    output logic [VIW-1:0]                o_row_ra,
    output logic [EIW-1:0]                o_nb_ra,
    output gdac_pkg::t_sel_status         o_status,
    output gdac_pkg::t_out_word           o_rec
);
    import gdac_pkg::*;

    logic covmem [MAX_NODES];
    logic r_covq;

    t_sel_state r_state, n_state;

    logic [NW-1:0]        r_v;
    logic                 r_sv;
    logic [VIW-1:0]       r_sidx;
    logic                 r_found;
    logic [VIW-1:0]       r_best;
    logic [EW-1:0]        r_best_start;
    logic [EW-1:0]        r_best_len;
    logic [EW-1:0]        r_idx;
    logic [EW-1:0]        r_p;
    logic [VIW-1:0]       r_w;
    logic                 r_wok;
    logic [10:0]          r_newly;
    logic [10:0]          r_total;
    logic [C_LIMIT_W-1:0] r_count;
    logic [C_LIMIT_W-1:0] r_limit;
    t_out_word            r_pend;
    logic                 r_pend_v;

    logic                 cov_we;
    logic [VIW-1:0]       cov_wa;
    logic                 cov_wd;
    logic [VIW-1:0]       cov_ra;
    logic                 push;
    logic                 push_last;
    logic [C_LIMIT_W-1:0] lim;

    always_comb begin
        if (i_limit == '0) begin
            lim = C_LIMIT_W'(1);
        end else if (32'(i_limit) > ANCHOR_CAP) begin
            lim = C_LIMIT_W'(ANCHOR_CAP);
        end else begin
            lim = i_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cov_we) begin
            covmem[cov_wa] <= cov_wd;
        end
        r_covq <= covmem[cov_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        cov_we    = 1'b0;
        cov_wa    = VIW'(r_v);
        cov_wd    = 1'b0;
        cov_ra    = VIW'(r_v);
        push      = 1'b0;
        push_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_run && i_vcount != '0) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cov_we = 1'b1;
                if (r_v == NW'(i_vcount - 1'b1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_v == NW'(i_vcount - 1'b1)) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_found) begin
                    n_state = r_pend_v ? S_FLUSH : S_IDLE;
                end else if (!r_pend_v) begin
                    n_state = S_MARK;
                end else if (i_out_free) begin
                    push    = 1'b1;
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                cov_we  = 1'b1;
                cov_wa  = r_best;
                cov_wd  = 1'b1;
                n_state = (r_best_len == '0) ? S_FIN : S_NBRD;
            end
            S_NBRD: begin
                n_state = S_CVRD;
            end
            S_CVRD: begin
                cov_ra  = VIW'(i_nb);
                n_state = S_CVEV;
            end
            S_CVEV: begin
                if (r_wok && !r_covq) begin
                    cov_we = 1'b1;
                    cov_wa = r_w;
                    cov_wd = 1'b1;
                end
                n_state = (EW'(r_p + 1'b1) == r_best_len) ? S_FIN : S_NBRD;
            end
            S_FIN: begin
                n_state = (C_LIMIT_W'(r_count + 1'b1) == r_limit) ? S_FLUSH : S_SCAN;
            end
            S_FLUSH: begin
                if (i_out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            r_sv   <= (r_state == S_SCAN);
            r_sidx <= VIW'(r_v);
            if (r_sv && !r_covq && (!r_found || i_row_len > r_best_len)) begin
                r_found      <= 1'b1;
                r_best       <= r_sidx;
                r_best_start <= i_row_start;
                r_best_len   <= i_row_len;
            end
            if (push) begin
                r_pend_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_v      <= '0;
                    r_count  <= '0;
                    r_total  <= '0;
                    r_pend_v <= 1'b0;
                    r_limit  <= lim;
                end
                S_CLEAR: begin
                    r_v <= (n_state == S_SCAN) ? '0 : r_v + 1'b1;
                    r_found <= 1'b0;
                end
                S_SCAN: begin
                    r_v <= r_v + 1'b1;
                end
                S_MARK: begin
                    r_newly <= 11'd1;
                    r_p     <= '0;
                    r_idx   <= r_best_start;
                end
                S_CVRD: begin
                    r_wok <= 32'(i_nb) < 32'(i_vcount);
                    r_w   <= VIW'(i_nb);
                end
                S_CVEV: begin
                    if (r_wok && !r_covq) begin
                        r_newly <= r_newly + 1'b1;
                    end
                    r_p   <= r_p + 1'b1;
                    r_idx <= r_idx + 1'b1;
                end
                S_FIN: begin
                    r_total              <= r_total + r_newly;
                    r_pend.step          <= 6'(r_count);
                    r_pend.anchor        <= 10'(r_best);
                    r_pend.degree        <= 14'(r_best_len);
                    r_pend.fresh_count   <= r_newly;
                    r_pend.cover_sum     <= r_total + r_newly;
                    r_pend.last          <= 1'b0;
                    r_pend_v             <= 1'b1;
                    r_count              <= r_count + 1'b1;
                    r_v                  <= '0;
                    r_found              <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_row_ra        = VIW'(r_v);
    assign o_nb_ra         = EIW'(r_idx);
    assign o_status.busy   = (r_state != S_IDLE);
    assign o_status.push   = push;

    always_comb begin
        o_rec      = r_pend;
        o_rec.last = push_last;
    end

endmodule

### rtl/greedy_degree_anchor_cover.sv
// ----------------------------------------------------------------------------
// Greedy degree anchor cover
// Loads a graph in row form and picks max-degree anchors until covered or the limit is hit.
// ----------------------------------------------------------------------------
// Input words carry an op and a neighbor id. A row word opens the next vertex
// and a neighbor word appends to the open row; load words stream at one per
// cycle while no pass runs. A run word starts a selection pass and holds
// o_in_stall high until the pass ends. A pass first clears the covered marks
// of all loaded vertices. Each anchor then scans all loaded vertices, marks
// the anchor, checks each neighbor entry of its row in three states (S_NBRD,
// S_CVRD, S_CVEV) and records the anchor, all through the registered-read
// covered-mark memory. A pass that runs out of uncovered vertices ends with
// one more scan, and the final word then leaves from the flush state.
// One output word per anchor leaves through an output register; the final
// word of a pass has last set. A stalled output holds its word and the pass
// waits for it before it reports the next anchor. Reset empties the graph,
// drops any pending output word and sets the anchor limit to 64. The limit
// register may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module greedy_degree_anchor_cover #(
    parameter int MAX_NODES   = gdac_pkg::C_MAX_NODES,
    parameter int MAX_EDGES   = gdac_pkg::C_MAX_EDGES,
    parameter int ANCHOR_CAP  = gdac_pkg::C_ANCHOR_CAP
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  gdac_pkg::t_in_word             i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output gdac_pkg::t_out_word            o_out,
    input  logic                           i_cfg_we,
    input  logic [gdac_pkg::C_LIMIT_W-1:0] i_cfg_wdata
);
    import gdac_pkg::*;

    localparam int VIW = $clog2(MAX_NODES);
    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int EIW = $clog2(MAX_EDGES);
    localparam int EW  = $clog2(MAX_EDGES + 1);

    logic [C_LIMIT_W-1:0] r_limit;
    logic                 r_out_v;
    t_out_word            r_out;

    logic                 accept;
    logic                 out_free;
    logic [VIW-1:0]       row_ra;
    logic [EIW-1:0]       nb_ra;
    logic [EW-1:0]        row_start;
    logic [EW-1:0]        row_len;
    logic [9:0]           nb;
    logic [NW-1:0]        vcount;
    t_sel_status          status;
    t_out_word            rec;

    assign accept   = i_in_valid && !status.busy;
    assign out_free = !r_out_v || !i_out_stall;

    gdac_graph #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_graph (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_word     (i_in),
        .i_row_ra   (row_ra),
        .i_nb_ra    (nb_ra),
        .o_row_start(row_start),
        .o_row_len  (row_len),
        .o_nb       (nb),
        .o_vcount   (vcount)
    );

    gdac_select #(
        .MAX_NODES  (MAX_NODES),
        .MAX_EDGES  (MAX_EDGES),
        .ANCHOR_CAP (ANCHOR_CAP)
    ) u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_run      (accept && i_in.op == OP_RUN),
        .i_limit    (r_limit),
        .i_vcount   (vcount),
        .i_row_start(row_start),
        .i_row_len  (row_len),
        .i_nb       (nb),
        .i_out_free (out_free),
        .o_row_ra   (row_ra),
        .o_nb_ra    (nb_ra),
        .o_status   (status),
        .o_rec      (rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= C_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (status.push) begin
            r_out_v <= 1'b1;
            r_out   <= rec;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_in_stall  = status.busy;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

### rtl/gdac_checker.sv
// ----------------------------------------------------------------------------
// Anchor cover port checker
// Port-level properties of the output stream, bound to the top level.
// ----------------------------------------------------------------------------
module gdac_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input gdac_pkg::t_out_word o_out
);
    import gdac_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output word changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_newly: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.fresh_count != 11'd0)
        else $error("anchor covered nothing");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.cover_sum >= o_out.fresh_count)
        else $error("running total below newly covered");

endmodule

bind greedy_degree_anchor_cover gdac_checker u_gdac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);
